### src/bcr_pkg.sv
// Shared types and constants for the balanced client registry.
package bcr_pkg;

  localparam int unsigned MAX_GROUPS = 8;
  localparam int unsigned CAPACITY   = 64;

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned GRP_W  = 3;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned GU_W   = 4;
  localparam int unsigned ADDR_W = 32;

  localparam logic [GU_W-1:0] GROUPS_RESET = GU_W'(5);

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_REMOVE   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] ip_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [GRP_W-1:0] group_index;
    logic [CNT_W-1:0] group_size;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [GRP_W-1:0]  grp;
  } entry_t;

  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_idx;
    logic              commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } ctrl_sts_t;

endpackage

### src/balanced_client_registry.sv
// Balanced client registry top level: APB register, sequencer and datapath.
//
// Registers or removes IPv4 client addresses across up to eight worker groups,
// placing new addresses in the least populated active group (lowest index on a
// tie) and answering with a status, the group and its member count. Each request
// scans all 64 entry slots, one entry RAM read per cycle, so a request holds the
// block through the accept cycle, the 64 scan reads, a drain cycle for the last
// compare and a commit cycle, and its result is registered in the commit cycle.
// The commit cycle stretches while the previous result is still stalled on
// out_ready_i. The next request is accepted the cycle after the result is
// registered, even while that result still waits on out_ready_i. groups_in_use
// sits at byte address 0, resets to 5, and must only be written while the block
// is idle.
module balanced_client_registry
  import bcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [GU_W-1:0] groups_q;
  logic            reg_sel;
  ctrl_cmd_t       cmd;
  ctrl_sts_t       sts;

  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32-GU_W){1'b0}}, groups_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= GROUPS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      groups_q <= pwdata[GU_W-1:0];
    end
  end

  bcr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bcr_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .groups_i   (groups_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### src/bcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/bcr_ctrl.sv
// Request sequencer: accept, scan every slot, commit the result.
module bcr_ctrl
  import bcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] ptr_q, ptr_d;

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.rd_idx = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ptr_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        ptr_d       = ptr_q + SLOT_W'(1);
        if (ptr_q == LAST_SLOT) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read's compare lands this cycle
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

endmodule

### src/bcr_datapath.sv
// Entry store, valid bits, group counters, scan compare and result register.
module bcr_datapath
  import bcr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       cmd_i,
  output ctrl_sts_t       sts_o,
  input  in_item_t        in_data_i,
  input  logic [GU_W-1:0] groups_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  logic [CAPACITY-1:0] valid_q;
  logic [CNT_W-1:0]    cnt_q [MAX_GROUPS];

  logic              req_op_q;
  logic [ADDR_W-1:0] req_addr_q;

  logic              pend_q;
  logic [SLOT_W-1:0] pend_idx_q;
  entry_t            rdata;

  logic              hit_q;
  logic [SLOT_W-1:0] hit_slot_q;
  logic [GRP_W-1:0]  hit_grp_q;
  logic              free_fnd_q;
  logic [SLOT_W-1:0] free_slot_q;

  logic [GRP_W-1:0]  best_q;

  logic              out_valid_q;
  out_item_t         out_q;

  logic              ram_we;
  entry_t            ram_wdata;

  // emptiest active group
  logic [GU_W-1:0]  n_eff;
  logic [GRP_W-1:0] best;
  logic [CNT_W-1:0] best_cnt;

  always_comb begin
    if (groups_i == '0) begin
      n_eff = GU_W'(1);
    end else if (groups_i > GU_W'(MAX_GROUPS)) begin
      n_eff = GU_W'(MAX_GROUPS);
    end else begin
      n_eff = groups_i;
    end
    best     = '0;
    best_cnt = cnt_q[0];
    for (int g = 1; g < MAX_GROUPS; g++) begin
      if (GU_W'(g) < n_eff && cnt_q[g] < best_cnt) begin
        best     = GRP_W'(g);
        best_cnt = cnt_q[g];
      end
    end
  end

  assign ram_we         = cmd_i.commit && (req_op_q == OP_REGISTER) && !hit_q && free_fnd_q;
  assign ram_wdata.addr = req_addr_q;
  assign ram_wdata.grp  = best_q;

  bcr_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_slot_q),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_idx),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_op_q   <= in_data_i.op;
      req_addr_q <= in_data_i.ip_addr;
    end
    pend_idx_q <= cmd_i.rd_idx;
    best_q     <= best;
    if (pend_q && valid_q[pend_idx_q] && rdata.addr == req_addr_q) begin
      hit_slot_q <= pend_idx_q;
      hit_grp_q  <= rdata.grp;
    end
    if (pend_q && !valid_q[pend_idx_q] && !free_fnd_q) begin
      free_slot_q <= pend_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      hit_q      <= 1'b0;
      free_fnd_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        hit_q      <= 1'b0;
        free_fnd_q <= 1'b0;
      end else if (pend_q) begin
        if (valid_q[pend_idx_q] && rdata.addr == req_addr_q) begin
          hit_q <= 1'b1;
        end
        if (!valid_q[pend_idx_q]) begin
          free_fnd_q <= 1'b1;
        end
      end
    end
  end

  // result of the committed request
  out_item_t        res;
  logic [CNT_W-1:0] hit_cnt;

  assign hit_cnt = cnt_q[hit_grp_q];

  always_comb begin
    res = '0;
    if (req_op_q == OP_REGISTER) begin
      if (hit_q) begin
        res.status      = ST_PRESENT;
        res.group_index = hit_grp_q;
        res.group_size  = hit_cnt;
      end else if (!free_fnd_q) begin
        res.status = ST_FULL;
      end else begin
        res.status      = ST_INSERTED;
        res.group_index = best_q;
        res.group_size  = cnt_q[best_q] + CNT_W'(1);
      end
    end else begin
      if (hit_q) begin
        res.status      = ST_REMOVED;
        res.group_index = hit_grp_q;
        res.group_size  = (hit_cnt != '0) ? hit_cnt - CNT_W'(1) : '0;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        cnt_q[g] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (ram_we) begin
        valid_q[free_slot_q] <= 1'b1;
        cnt_q[best_q]        <= res.group_size;
      end else if (req_op_q == OP_REMOVE && hit_q) begin
        valid_q[hit_slot_q] <= 1'b0;
        cnt_q[hit_grp_q]    <= res.group_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

### src/bcr_checker.sv
// Port-level checks for the balanced client registry, bound to the top level.
module bcr_checker
  import bcr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one request at a time: busy right after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !(out_valid_o && $rose(out_valid_o)))
    else $error("request overlap after accept");

  // misses carry no group and no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL || out_data_o.status == ST_NOT_FOUND)
    |-> out_data_o.group_index == '0 && out_data_o.group_size == '0)
    else $error("miss result with nonzero group fields");

  // an insert always leaves its group populated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_INSERTED |-> out_data_o.group_size != '0)
    else $error("insert reported empty group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_FULL)
    else $error("unknown status code");

endmodule

bind balanced_client_registry bcr_checker u_bcr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
